### rtl/length_prefixed_field_deframer_core_macros.svh
// Assertion macros used by the deframer core.
`ifndef LENGTH_PREFIXED_FIELD_DEFRAMER_CORE_MACROS_SVH
`define LENGTH_PREFIXED_FIELD_DEFRAMER_CORE_MACROS_SVH

// Condition implies consequence in the same cycle.
`define LPFD_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("lpfd assertion failed");

// Condition implies consequence in the next cycle.
`define LPFD_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("lpfd assertion failed");

`endif

### rtl/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared constants and types of the length-prefixed field deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpfd_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int MAX_FIELDS  = 64;
    localparam int FC_BITS     = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_0   = 8'h30;
    localparam logic [7:0] CHAR_9   = 8'h39;

    typedef logic [LENGTH_BITS-1:0] t_len;
    typedef logic [FC_BITS-1:0]     t_fcnt;

    // Byte held in the input register, offered to the parser.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_in_req;

    typedef struct packed {
        logic [5:0]  field_number;
        logic [7:0]  payload_byte;
        logic [15:0] byte_position;
        logic        empty_field;
        logic        last_in_field;
        logic        last_in_message;
        logic        format_error;
    } t_result;

endpackage

### rtl/length_prefixed_field_deframer_core.sv
// The accepted byte waits in the input register; the result register is loaded when the
// parser takes it, so each result passes the input register and then the result register.
// Throughput: one byte per cycle unless an untaken result stalls; the parser state update is the only loop.
// A waiting result does not block intake while the consumer takes it.
// Reset (synchronous, active low) returns to the header phase, clears counters.
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// length_prefixed_field_deframer_core
// Deframes length-prefixed messages into per-byte field results.
// ----------------------------------------------------------------------------
`include "length_prefixed_field_deframer_core_macros.svh"

module length_prefixed_field_deframer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_field_number,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_byte_position,
    output logic        o_empty_field,
    output logic        o_last_in_field,
    output logic        o_last_in_message,
    output logic        o_format_error
);

    lpfd_pkg::t_in_req in_req;
    lpfd_pkg::t_result result;
    logic              take;
    logic              empty_ok;

    lpfd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_in_byte (i_in_byte),
        .i_take    (take),
        .o_req     (in_req)
    );

    lpfd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (in_req),
        .o_take   (take),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (result)
    );

    assign o_field_number    = result.field_number;
    assign o_payload_byte    = result.payload_byte;
    assign o_byte_position   = result.byte_position;
    assign o_empty_field     = result.empty_field;
    assign o_last_in_field   = result.last_in_field;
    assign o_last_in_message = result.last_in_message;
    assign o_format_error    = result.format_error;

    assign empty_ok = o_last_in_field && (o_payload_byte == 8'd0) && (o_byte_position == 16'd0);

    // An empty field result carries zero data and closes its field.
    `LPFD_ASSERT_SAME(a_empty_shape, i_clk, i_rst_n, o_valid && o_empty_field, empty_ok)
    // The end of a message always ends the field too.
    `LPFD_ASSERT_SAME(a_msg_ends_field, i_clk, i_rst_n, o_valid && o_last_in_message, o_last_in_field)
    // A held input byte the parser cannot take must stall the input side.
    `LPFD_ASSERT_SAME(a_stall_back, i_clk, i_rst_n, in_req.valid && !take, !o_ready)
    // A result that was not taken is still there in the next cycle.
    `LPFD_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_valid && !i_ready, o_valid)

endmodule

### rtl/lpfd_in_stage.sv
// ----------------------------------------------------------------------------
// lpfd_in_stage
// Input register: holds one incoming byte until the parser takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpfd_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_in_byte,
    input  logic             i_take,
    output lpfd_pkg::t_in_req o_req
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_req   = '{valid: r_valid, data: r_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_in_byte;
        end
    end

endmodule

### rtl/lpfd_parser.sv
// ----------------------------------------------------------------------------
// lpfd_parser
// Deframing state machine and result register. One byte is processed per
// cycle whenever the result register is free or being drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpfd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpfd_pkg::t_in_req i_req,
    output logic              o_take,
    output logic              o_valid,
    input  logic              i_ready,
    output lpfd_pkg::t_result o_result
);

    localparam int LB = lpfd_pkg::LENGTH_BITS;

    typedef enum logic [1:0] {
        PH_HEADER    = 2'd0,
        PH_FIELD_LEN = 2'd1,
        PH_PAYLOAD   = 2'd2
    } t_phase;

    typedef struct packed {
        lpfd_pkg::t_len acc;
        logic           ended;
        logic           sat;
    } t_digit_res;

    // One step of atoi-style accumulation with saturation.
    function automatic t_digit_res f_digit(lpfd_pkg::t_len acc, logic [7:0] b, logic ended);
        logic [LB+3:0] v;
        t_digit_res    res;
        res.acc   = acc;
        res.ended = ended;
        res.sat   = 1'b0;
        v = (LB+4)'(acc) * (LB+4)'(10) + (LB+4)'(b - lpfd_pkg::CHAR_0);
        if (!ended) begin
            if (!(b inside {[lpfd_pkg::CHAR_0:lpfd_pkg::CHAR_9]})) begin
                res.ended = 1'b1;
            end else if (v > (LB+4)'({LB{1'b1}})) begin
                res.acc = {LB{1'b1}};
                res.sat = 1'b1;
            end else begin
                res.acc = v[LB-1:0];
            end
        end
        return res;
    endfunction

    t_phase            r_phase, n_phase;
    lpfd_pkg::t_len    r_total, n_total;
    lpfd_pkg::t_len    r_consumed, n_consumed;
    lpfd_pkg::t_len    r_field_len, n_field_len;
    lpfd_pkg::t_len    r_payload, n_payload;
    lpfd_pkg::t_fcnt   r_fcnt, n_fcnt;
    logic              r_ended, n_ended;
    logic              r_error, n_error;
    logic              r_out_valid, n_out_valid;
    lpfd_pkg::t_result r_result, n_result;

    logic [LB:0] consumed_inc;
    logic [LB:0] payload_inc;
    logic        msg_end;
    logic        last_field;
    logic        end_field;
    logic        end_msg;
    logic [7:0]  b;
    t_digit_res  dig;

    assign o_take   = i_req.valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    assign b            = i_req.data;
    assign consumed_inc = {1'b0, r_consumed} + (LB+1)'(1);
    assign payload_inc  = {1'b0, r_payload} + (LB+1)'(1);
    assign msg_end      = consumed_inc >= {1'b0, r_total};
    assign last_field   = (payload_inc >= {1'b0, r_field_len}) || msg_end;

    always_comb begin
        n_phase     = r_phase;
        n_total     = r_total;
        n_consumed  = r_consumed;
        n_field_len = r_field_len;
        n_payload   = r_payload;
        n_fcnt      = r_fcnt;
        n_ended     = r_ended;
        n_error     = r_error;
        n_out_valid = r_out_valid && !i_ready;
        n_result    = r_result;
        end_field   = 1'b0;
        end_msg     = 1'b0;
        dig         = '0;

        case (r_phase)
            PH_FIELD_LEN: begin
                n_consumed = consumed_inc[LB-1:0];
                if (b == lpfd_pkg::CHAR_NUL) begin
                    if (r_field_len == '0) begin
                        n_out_valid              = 1'b1;
                        n_result.field_number    = 6'(r_fcnt);
                        n_result.payload_byte    = 8'd0;
                        n_result.byte_position   = 16'd0;
                        n_result.empty_field     = 1'b1;
                        n_result.last_in_field   = 1'b1;
                        n_result.last_in_message = msg_end;
                        n_result.format_error    = r_error;
                        end_field                = 1'b1;
                    end else if (msg_end) begin
                        end_msg = 1'b1;
                    end else begin
                        n_phase   = PH_PAYLOAD;
                        n_payload = '0;
                    end
                end else begin
                    dig         = f_digit(r_field_len, b, r_ended);
                    n_field_len = dig.acc;
                    n_ended     = dig.ended;
                    n_error     = r_error || dig.sat;
                    end_msg     = msg_end;
                end
            end
            PH_PAYLOAD: begin
                n_consumed               = consumed_inc[LB-1:0];
                n_out_valid              = 1'b1;
                n_result.field_number    = 6'(r_fcnt);
                n_result.payload_byte    = b;
                n_result.byte_position   = 16'(r_payload);
                n_result.empty_field     = 1'b0;
                n_result.last_in_field   = last_field;
                n_result.last_in_message = msg_end;
                n_result.format_error    = r_error;
                n_payload                = payload_inc[LB-1:0];
                end_field                = last_field;
            end
            default: begin
                // Header phase; the unused phase code behaves the same way.
                if (b == lpfd_pkg::CHAR_NUL) begin
                    if (r_total == '0) begin
                        end_msg = 1'b1;
                    end else begin
                        n_phase     = PH_FIELD_LEN;
                        n_consumed  = '0;
                        n_field_len = '0;
                        n_payload   = '0;
                        n_fcnt      = '0;
                        n_ended     = 1'b0;
                    end
                end else begin
                    dig     = f_digit(r_total, b, r_ended);
                    n_total = dig.acc;
                    n_ended = dig.ended;
                    n_error = r_error || dig.sat;
                end
            end
        endcase

        if (end_field) begin
            if (msg_end) begin
                end_msg = 1'b1;
            end else begin
                n_phase     = PH_FIELD_LEN;
                n_field_len = '0;
                n_payload   = '0;
                n_ended     = 1'b0;
                if (({1'b0, r_fcnt} + (lpfd_pkg::FC_BITS+1)'(1)) <
                    (lpfd_pkg::FC_BITS+1)'(lpfd_pkg::MAX_FIELDS)) begin
                    n_fcnt = r_fcnt + lpfd_pkg::FC_BITS'(1);
                end else begin
                    n_error = 1'b1;
                end
            end
        end

        if (end_msg) begin
            n_phase     = PH_HEADER;
            n_total     = '0;
            n_consumed  = '0;
            n_field_len = '0;
            n_payload   = '0;
            n_fcnt      = '0;
            n_ended     = 1'b0;
            n_error     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_total     <= '0;
            r_consumed  <= '0;
            r_field_len <= '0;
            r_payload   <= '0;
            r_fcnt      <= '0;
            r_ended     <= 1'b0;
            r_error     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_phase     <= n_phase;
            r_total     <= n_total;
            r_consumed  <= n_consumed;
            r_field_len <= n_field_len;
            r_payload   <= n_payload;
            r_fcnt      <= n_fcnt;
            r_ended     <= n_ended;
            r_error     <= n_error;
            r_out_valid <= n_out_valid;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_result <= n_result;
        end
    end

endmodule

### test/tb_length_prefixed_field_deframer_core.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// tb_length_prefixed_field_deframer_core
// Sends framed messages into the deframer one byte per request and checks
// every field result against a cycle-free model of the parser or a hand-written
// directed result. A short directed table comes first. Random messages follow:
// well-formed, cut short, field-count overflow, saturated lengths, empty headers and junk.
// ----------------------------------------------------------------------------

module tb_length_prefixed_field_deframer_core;
    import lpfd_pkg::*;

    localparam int RANDOM_ITEMS = 1350;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 10;
    localparam longint unsigned LEN_MAX = (64'd1 << LENGTH_BITS) - 64'd1;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_SPARE   = 2'd3
    } t_phase;

    typedef logic [7:0] t_bytes[$];

    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        logic       typed_has;
        t_result    res;
    } t_row;

    localparam t_result NO_RES     = '0;
    localparam t_result EMPTY_LAST = '{6'd0, 8'h00, 16'd0, 1'b1, 1'b1, 1'b1, 1'b0};
    localparam t_result SAT_FIRST  = '{6'd0, 8'hFF, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1};
    localparam t_result SAT_CUT    = '{6'd0, 8'h80, 16'd1, 1'b0, 1'b1, 1'b1, 1'b1};

    localparam int N_DIRECTED = 28;
    localparam t_row DIRECTED_ROWS [N_DIRECTED] = '{
        // Right after reset: total 2, a single empty field.
        '{"2",      1'b0, 1'b0, NO_RES},
        '{CHAR_NUL, 1'b0, 1'b0, NO_RES},
        '{"0",      1'b0, 1'b0, NO_RES},
        '{CHAR_NUL, 1'b1, 1'b1, EMPTY_LAST},
        // Empty messages: a zero total, then a total that starts with a sign.
        '{"0",      1'b0, 1'b0, NO_RES},
        '{CHAR_NUL, 1'b1, 1'b0, NO_RES},
        '{"+",      1'b0, 1'b0, NO_RES},
        '{"5",      1'b0, 1'b0, NO_RES},
        '{CHAR_NUL, 1'b1, 1'b0, NO_RES},
        // Field length 70000 saturates; the message ends inside the payload.
        '{"8",      1'b0, 1'b0, NO_RES},
        '{CHAR_NUL, 1'b0, 1'b0, NO_RES},
        '{"7",      1'b0, 1'b0, NO_RES},
        '{"0",      1'b0, 1'b0, NO_RES},
        '{"0",      1'b0, 1'b0, NO_RES},
        '{"0",      1'b0, 1'b0, NO_RES},
        '{"0",      1'b0, 1'b0, NO_RES},
        '{CHAR_NUL, 1'b0, 1'b0, NO_RES},
        '{8'hFF,    1'b1, 1'b1, SAT_FIRST},
        '{8'h80,    1'b1, 1'b1, SAT_CUT},
        // The message ends on a length digit.
        '{"2",      1'b0, 1'b0, NO_RES},
        '{CHAR_NUL, 1'b0, 1'b0, NO_RES},
        '{"1",      1'b0, 1'b0, NO_RES},
        '{"5",      1'b1, 1'b0, NO_RES},
        // The message ends on the NUL of a nonzero length with a trailing letter.
        '{"3",      1'b0, 1'b0, NO_RES},
        '{CHAR_NUL, 1'b0, 1'b0, NO_RES},
        '{"1",      1'b0, 1'b0, NO_RES},
        '{"a",      1'b0, 1'b0, NO_RES},
        '{CHAR_NUL, 1'b1, 1'b0, NO_RES}
    };

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_ready   = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [5:0]  o_field_number;
    logic [7:0]  o_payload_byte;
    logic [15:0] o_byte_position;
    logic        o_empty_field;
    logic        o_last_in_field;
    logic        o_last_in_message;
    logic        o_format_error;

    // Hand-written result that travels along with a directed request.
    logic    req_typed     = 1'b0;
    logic    req_typed_has = 1'b0;
    t_result req_typed_res = '0;

    // Parser state of the model.
    t_phase ph          = PH_HEADER;
    t_len   msg_total   = '0;
    t_len   body_seen   = '0;
    t_len   fld_len     = '0;
    t_len   fld_pos     = '0;
    t_fcnt  fld_idx     = '0;
    logic   digits_done = 1'b0;
    logic   fmt_err     = 1'b0;

    t_result    expected_field_bytes[$];
    logic [7:0] msg_q[$];
    logic [7:0] body_q[$];

    int mismatch_count  = 0;
    int cycle_count     = 0;
    int msg_count       = 0;
    int bytes_sent      = 0;
    int random_sent     = 0;
    int results_checked = 0;
    int flagged_results = 0;
    int message_ends    = 0;
    int rx_count        = 0;
    bit tx_burst        = 1'b0;
    bit rx_burst        = 1'b0;

    length_prefixed_field_deframer_core uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_in_byte         (i_in_byte),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_field_number    (o_field_number),
        .o_payload_byte    (o_payload_byte),
        .o_byte_position   (o_byte_position),
        .o_empty_field     (o_empty_field),
        .o_last_in_field   (o_last_in_field),
        .o_last_in_message (o_last_in_message),
        .o_format_error    (o_format_error)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Model of the parser
    // ------------------------------------------------------------------

    function automatic void clear_message();
        ph          = PH_HEADER;
        msg_total   = '0;
        body_seen   = '0;
        fld_len     = '0;
        fld_pos     = '0;
        fld_idx     = '0;
        digits_done = 1'b0;
        fmt_err     = 1'b0;
    endfunction

    // Decimal digits build the value until the first non-digit; the rest is ignored.
    function automatic t_len add_digit(t_len acc, logic [7:0] b);
        longint unsigned v;
        if (digits_done)
            return acc;
        if (b < CHAR_0 || b > CHAR_9) begin
            digits_done = 1'b1;
            return acc;
        end
        v = longint'(acc) * 10 + longint'(b - CHAR_0);
        if (v > LEN_MAX) begin
            v       = LEN_MAX;
            fmt_err = 1'b1;
        end
        return t_len'(v);
    endfunction

    function automatic void finish_field(logic msg_end);
        if (msg_end) begin
            clear_message();
            return;
        end
        ph          = PH_LENGTH;
        fld_len     = '0;
        fld_pos     = '0;
        digits_done = 1'b0;
        if (int'(fld_idx) + 1 < MAX_FIELDS)
            fld_idx = fld_idx + 1'b1;
        else
            fmt_err = 1'b1;
    endfunction

    function automatic t_result make_result(logic [7:0] b, t_len pos, logic empty,
                                            logic lf, logic lm);
        t_result r;
        r.field_number    = 6'(fld_idx);
        r.payload_byte    = b;
        r.byte_position   = 16'(pos);
        r.empty_field     = empty;
        r.last_in_field   = lf;
        r.last_in_message = lm;
        r.format_error    = fmt_err;
        return r;
    endfunction

    function automatic bit deframe_byte(logic [7:0] b, output t_result r);
        logic msg_end;
        logic lf;
        r = '0;
        case (ph)
            PH_LENGTH: begin
                body_seen = body_seen + 1'b1;
                msg_end   = (body_seen >= msg_total);
                if (b == CHAR_NUL) begin
                    if (fld_len == '0) begin
                        r = make_result(8'h00, '0, 1'b1, 1'b1, msg_end);
                        finish_field(msg_end);
                        return 1'b1;
                    end
                    // A nonzero length cut off by the message end is dropped.
                    if (msg_end) begin
                        clear_message();
                        return 1'b0;
                    end
                    ph      = PH_PAYLOAD;
                    fld_pos = '0;
                    return 1'b0;
                end
                fld_len = add_digit(fld_len, b);
                if (msg_end)
                    clear_message();
                return 1'b0;
            end
            PH_PAYLOAD: begin
                body_seen = body_seen + 1'b1;
                msg_end   = (body_seen >= msg_total);
                lf        = (longint'(fld_pos) + 1 >= longint'(fld_len)) || msg_end;
                r         = make_result(b, fld_pos, 1'b0, lf, msg_end);
                fld_pos   = fld_pos + 1'b1;
                if (lf)
                    finish_field(msg_end);
                return 1'b1;
            end
            default: begin
                if (b == CHAR_NUL) begin
                    if (msg_total == '0) begin
                        clear_message();
                    end else begin
                        ph          = PH_LENGTH;
                        body_seen   = '0;
                        fld_len     = '0;
                        fld_pos     = '0;
                        fld_idx     = '0;
                        digits_done = 1'b0;
                    end
                    return 1'b0;
                end
                msg_total = add_digit(msg_total, b);
                return 1'b0;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : predict_results
        t_result pred;
        bit      has;
        if (!i_rst_n) begin
            clear_message();
        end else if (i_valid && o_ready) begin
            has = deframe_byte(i_in_byte, pred);
            if (req_typed) begin
                if (req_typed_has)
                    expected_field_bytes.push_back(req_typed_res);
            end else if (has) begin
                expected_field_bytes.push_back(pred);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void compare_field(string name, longint unsigned want,
                                          longint unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_field_bytes.size() == 0) begin
                $error("Result with no request pending: field %0d byte 0x%02h",
                       o_field_number, o_payload_byte);
                mismatch_count++;
            end else begin
                want = expected_field_bytes.pop_front();
                compare_field("field_number", want.field_number, o_field_number);
                compare_field("payload_byte", want.payload_byte, o_payload_byte);
                compare_field("byte_position", want.byte_position, o_byte_position);
                compare_field("empty_field", want.empty_field, o_empty_field);
                compare_field("last_in_field", want.last_in_field, o_last_in_field);
                compare_field("last_in_message", want.last_in_message,
                              o_last_in_message);
                compare_field("format_error", want.format_error, o_format_error);
                results_checked++;
                flagged_results += o_format_error;
                message_ends    += o_last_in_message;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("Timed out after %0d cycles with %0d results outstanding",
                   cycle_count, expected_field_bytes.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Message generation
    // ------------------------------------------------------------------

    function automatic logic [7:0] non_digit_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b >= CHAR_0 && b <= CHAR_9);
        return b;
    endfunction

    // Decimal text of a length with its NUL. Unless plain, it may carry leading
    // zeros or a trailing non-digit, and a zero may be spelled as a non-digit.
    function automatic t_bytes length_text(longint unsigned v, bit plain);
        t_bytes t;
        string  s;
        s = $sformatf("%0d", v);
        if (v == 0 && !plain && $urandom_range(0, 4) == 0) begin
            t.push_back(non_digit_byte());
            if ($urandom_range(0, 1) == 1)
                t.push_back("7");
        end else begin
            if (!plain && $urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 2)) t.push_back(CHAR_0);
            for (int i = 0; i < s.len(); i++)
                t.push_back(s[i]);
            if (!plain && $urandom_range(0, 9) == 0)
                t.push_back(non_digit_byte());
        end
        t.push_back(CHAR_NUL);
        return t;
    endfunction

    function automatic int unsigned random_length();
        if ($urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(9, 24);
        return $urandom_range(1, 8);
    endfunction

    task automatic add_field(input int unsigned len);
        body_q = {body_q, length_text(len, 1'b0)};
        repeat (len) body_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_message();
        int unsigned kind;
        int unsigned total;
        kind  = $urandom_range(0, 99);
        total = 0;
        body_q.delete();
        msg_q.delete();
        if (kind < 72) begin
            repeat ($urandom_range(1, 5)) add_field(random_length());
            total = body_q.size();
            // Some messages declare fewer bytes than their fields need.
            if (kind >= 60)
                total = $urandom_range(1, body_q.size());
        end else if (kind < 80) begin
            // Close to MAX_FIELDS fields, which may drive the field counter past its limit.
            repeat ($urandom_range(MAX_FIELDS - 4, MAX_FIELDS + 6))
                add_field(($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0);
            total = body_q.size();
            if ($urandom_range(0, 3) == 0)
                total = $urandom_range(1, body_q.size());
        end else if (kind < 88) begin
            if ($urandom_range(0, 1) == 1)
                add_field(random_length());
            body_q = {body_q, length_text(LEN_MAX + $urandom_range(1, 999999), 1'b1)};
            repeat ($urandom_range(1, 12)) body_q.push_back(8'($urandom_range(0, 255)));
            total = body_q.size();
        end
        if (kind >= 94) begin
            // Junk header: a leading non-digit makes the total zero.
            msg_q.push_back(non_digit_byte());
            repeat ($urandom_range(0, 5)) msg_q.push_back(8'($urandom_range(1, 255)));
            msg_q.push_back(CHAR_NUL);
        end else if (total == 0) begin
            msg_q = length_text(0, 1'b0);
        end else begin
            msg_q = {length_text(total, 1'b0), body_q[0:total-1]};
        end
    endtask

    // ------------------------------------------------------------------
    // Request and result sides
    // ------------------------------------------------------------------

    task automatic send_byte(input t_row row);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_in_byte     <= row.data;
        req_typed     <= row.typed;
        req_typed_has <= row.typed_has;
        req_typed_res <= row.res;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_field_bytes.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin : result_sink
        int unsigned stall;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            rx_count++;
            if (rx_count % 32 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_byte(DIRECTED_ROWS[i]);
        wait_for_results();

        while (random_sent < RANDOM_ITEMS) begin
            build_message();
            tx_burst = ($urandom_range(0, 4) == 0);
            foreach (msg_q[j]) begin
                send_byte(t_row'{msg_q[j], 1'b0, 1'b0, NO_RES});
                random_sent++;
            end
            msg_count++;
            // Now and then hold the next request until the output has drained.
            if (msg_count % 40 == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes (%0d random messages); checked %0d field results.",
                 bytes_sent, msg_count, results_checked);
        $display("%0d results closed a message and %0d carried the format error flag.",
                 message_ends, flagged_results);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### length_prefixed_field_deframer_core.f
+incdir+rtl
rtl/lpfd_pkg.sv
rtl/lpfd_in_stage.sv
rtl/lpfd_parser.sv
rtl/length_prefixed_field_deframer_core.sv
test/tb_length_prefixed_field_deframer_core.sv
